@@ rtl/core/aqfir_pkg.sv @@
package aqfir_pkg;

  localparam int unsigned QBits    = 20;
  localparam int unsigned DataW    = 32;
  localparam int unsigned WeightW  = 22;
  localparam int unsigned ClampW   = 6;
  localparam int unsigned ProfW    = 3;
  localparam int unsigned EnergyW  = 68;

  localparam logic [ProfW-1:0] PROF_OFF   = 3'd0;
  localparam logic [ProfW-1:0] PROF_O8S3  = 3'd1;
  localparam logic [ProfW-1:0] PROF_O8S5  = 3'd2;
  localparam logic [ProfW-1:0] PROF_O32S3 = 3'd3;
  localparam logic [ProfW-1:0] PROF_O32S5 = 3'd4;

  localparam logic CFG_PROFILE = 1'b0;
  localparam logic CFG_INVERSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_PRED,
    ST_ADAPT,
    ST_ESUB,
    ST_ENERGY,
    ST_DONE
  } aqfir_state_t;

endpackage

@@ rtl/core/adaptive_q20_fir_residual_filter_unit.sv @@
// Adaptive Q20 FIR residual filter: normalised LMS predictor over a history ring
// of up to MAX_TAPS samples. One word in, one word out (order 0, 8 or 32). The
// weights adapt on every fourth sample when the order is not 0. Ready returns on
// the same edge as the result word appears. The single multiplier visits one tap
// per cycle for the prediction sum, again for the update, and then forms the
// outgoing and incoming squares of the energy; ready is low while a word is
// being worked on. block_start clears all filter state before that word is
// used. The result register lets the next word be taken while a result still
// waits.
module adaptive_q20_fir_residual_filter_unit
  import aqfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [ProfW-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DataW-1:0]  in_sample,
  input  logic                     in_block_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DataW-1:0]  out_result_sample,
  output logic signed [DataW-1:0]  out_prediction_value,
  output logic                     out_prediction_clamped,
  output logic                     out_modular_wrapped,
  output logic [ClampW-1:0]        out_coefficient_clamps,
  output logic                     out_adapted
);

  localparam int unsigned IdxW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TAPS + 1);

  // Config
  logic [ProfW-1:0] profile_r;
  logic             inverse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= PROF_OFF;
      inverse_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROFILE: profile_r <= cfg_data;
        CFG_INVERSE: inverse_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Order and shift from profile; order limited to MAX_TAPS
  logic [CntW-1:0] order;
  logic [2:0]      bshift;
  always_comb begin
    order  = '0;
    bshift = 3'd3;
    unique case (profile_r)
      PROF_O8S3:  begin order = CntW'((MAX_TAPS < 8) ? MAX_TAPS : 8);  bshift = 3'd3; end
      PROF_O8S5:  begin order = CntW'((MAX_TAPS < 8) ? MAX_TAPS : 8);  bshift = 3'd5; end
      PROF_O32S3: begin order = CntW'((MAX_TAPS < 32) ? MAX_TAPS : 32); bshift = 3'd3; end
      PROF_O32S5: begin order = CntW'((MAX_TAPS < 32) ? MAX_TAPS : 32); bshift = 3'd5; end
      default: ;
    endcase
  end

  // Filter state: small arrays, cleared by block_start when its word is taken
  logic signed [WeightW-1:0] weight_r [MAX_TAPS];
  logic signed [DataW-1:0]   hist_r   [MAX_TAPS];
  logic [IdxW-1:0]           head_r;
  logic [EnergyW-1:0]        energy_r;
  logic [1:0]                phase_r;

  aqfir_state_t    state_r, state_nxt;
  logic [CntW-1:0] j_r;
  logic [IdxW-1:0] hidx_r;          // (head + j) mod order
  logic signed [DataW-1:0] x_r;
  logic signed [70:0] acc_r;        // sum of up to 32 products of 54 bits
  logic signed [DataW-1:0] pred_r;
  logic                    pclamp_r;
  logic signed [33:0]      diff_r;
  logic signed [DataW-1:0] orig_r;
  logic [ClampW-1:0]       clamps_r;
  logic                    adapted_r;
  logic [6:0]              lg_r;    // ceil_log2(energy)
  logic [IdxW-1:0]         nh_r;

  // Shared multiplier: one 34x32 signed product per cycle
  logic signed [33:0] mul_a;
  logic signed [DataW-1:0] mul_b;
  logic signed [65:0] prod;
  logic signed [DataW-1:0] h_cur;
  assign h_cur = hist_r[hidx_r];
  always_comb begin
    mul_b = h_cur;
    if (state_r == ST_ADAPT) mul_a = diff_r;
    else if (state_r == ST_ESUB) begin
      mul_a = 34'(hist_r[nh_r]);
      mul_b = hist_r[nh_r];
    end else if (state_r == ST_ENERGY) begin
      mul_a = 34'(orig_r);
      mul_b = orig_r;
    end else mul_a = 34'(weight_r[j_r[IdxW-1:0]]);
  end
  assign prod = mul_a * mul_b;

  // ceil_log2 of energy = bit length of (energy - 1)
  logic [EnergyW-1:0] em1;
  logic [6:0]         bl;
  assign em1 = energy_r - EnergyW'(1);
  always_comb begin
    bl = '0;
    for (int i = 0; i < EnergyW; i++) if (em1[i]) bl = 7'(i + 1);
  end

  // Prediction: floor division by 2^20 then clamp
  logic signed [50:0] fl;
  logic signed [DataW-1:0] pred_c;
  logic pclamp_c;
  assign fl = 51'(acc_r >>> QBits);
  always_comb begin
    pclamp_c = 1'b0;
    pred_c   = fl[DataW-1:0];
    if (fl < -51'sd2147483648) begin pred_c = 32'sh80000000; pclamp_c = 1'b1; end
    else if (fl > 51'sd2147483647) begin pred_c = 32'sh7fffffff; pclamp_c = 1'b1; end
  end

  // Weight step: trunc(|d*h| * 2^(20-L-B)) capped at 2^22
  logic signed [7:0] sh;
  logic [65:0] mag;
  logic [22:0] q;
  logic signed [WeightW+1:0] wsum;
  logic signed [WeightW-1:0] wnew;
  logic wclamp;
  logic [65:0] shifted;
  assign sh  = $signed({1'b0, lg_r}) + $signed({5'b0, bshift}) - 8'sd20;
  assign mag = prod[65] ? 66'(-prod) : 66'(prod);
  always_comb begin
    shifted = '0;
    if (sh >= 8'sd66) shifted = '0;
    else if (sh >= 0) shifted = mag >> sh;
    else if ((mag >> (-sh)) != '0 && (mag << (-sh)) >> (-sh) != mag) shifted = 66'd4194304;
    else shifted = mag << (-sh);
    q = (shifted > 66'd4194304) ? 23'd4194304 : shifted[22:0];
    wsum = (WeightW+2)'(weight_r[j_r[IdxW-1:0]])
         + (prod[65] ? -(WeightW+2)'($signed({1'b0, q})) : (WeightW+2)'($signed({1'b0, q})));
    wclamp = 1'b1;
    if (wsum < -(WeightW+2)'(1 << QBits)) wnew = -WeightW'(1 << QBits);
    else if (wsum > (WeightW+2)'(1 << QBits)) wnew = WeightW'(1 << QBits);
    else begin wnew = wsum[WeightW-1:0]; wclamp = 1'b0; end
  end

  // Ring index step
  logic [IdxW-1:0] hidx_inc;
  assign hidx_inc = (CntW'(hidx_r) + CntW'(1) >= order) ? '0 : IdxW'(CntW'(hidx_r) + CntW'(1));

  logic signed [DataW-1:0] orig_c;
  assign orig_c = inverse_r ? (x_r + pred_c) : x_r;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MAC;
      ST_MAC:    if (j_r >= order) state_nxt = ST_PRED;
      ST_PRED:   state_nxt = (order != 0 && phase_r == 2'd3) ? ST_ADAPT : ST_ESUB;
      ST_ADAPT:  if (j_r + CntW'(1) >= order) state_nxt = ST_ESUB;
      ST_ESUB:   state_nxt = ST_ENERGY;
      ST_ENERGY: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // head mod order: the order is 8 or the largest order, and head always lies
  // below the largest order, so masking to three bits is enough
  logic [IdxW-1:0] head_mod;
  assign head_mod = (order == '0) ? '0 :
                    (CntW'(head_r) >= order) ? (head_r & IdxW'(7)) : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin weight_r[i] <= '0; hist_r[i] <= '0; end
      head_r <= '0; energy_r <= EnergyW'(1); phase_r <= '0; out_valid <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          x_r <= in_sample; acc_r <= '0; j_r <= '0; clamps_r <= '0; adapted_r <= 1'b0;
          if (in_block_start) begin
            for (int i = 0; i < MAX_TAPS; i++) begin weight_r[i] <= '0; hist_r[i] <= '0; end
            head_r <= '0; energy_r <= EnergyW'(1); phase_r <= '0; hidx_r <= '0;
          end else hidx_r <= head_mod;
        end
        ST_MAC: if (j_r < order) begin
          acc_r <= acc_r + 71'(prod); j_r <= j_r + CntW'(1); hidx_r <= hidx_inc;
        end
        ST_PRED: begin
          pred_r <= pred_c; pclamp_r <= pclamp_c; orig_r <= orig_c;
          diff_r <= 34'(orig_c) - 34'(pred_c);
          lg_r <= bl; j_r <= '0;
          hidx_r <= head_mod;
          // slot just below head, wrapping to the top of the ring
          nh_r <= (order == 0) ? '0 :
                  (head_mod == '0) ? IdxW'(order - CntW'(1)) : head_mod - IdxW'(1);
          adapted_r <= (order != 0 && phase_r == 2'd3);
        end
        ST_ADAPT: begin
          weight_r[j_r[IdxW-1:0]] <= wnew;
          clamps_r <= clamps_r + ClampW'(wclamp);
          j_r <= j_r + CntW'(1); hidx_r <= hidx_inc;
        end
        ST_ESUB: begin
          // square of the entry about to be overwritten leaves the energy
          if (order != 0) energy_r <= energy_r - EnergyW'(prod);
        end
        ST_ENERGY: begin
          if (order != 0) begin
            energy_r <= energy_r + EnergyW'(prod);
            head_r <= nh_r;
            hist_r[nh_r] <= orig_r;
          end
          phase_r <= phase_r + 2'd1;
        end
        ST_DONE: if (out_free) begin
          out_result_sample <= inverse_r ? orig_r : (x_r - pred_r);
          out_prediction_value <= pred_r;
          out_prediction_clamped <= pclamp_r;
          out_modular_wrapped <= (diff_r < -34'sd2147483648) || (diff_r > 34'sd2147483647);
          out_coefficient_clamps <= clamps_r;
          out_adapted <= adapted_r;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/sv/adaptive_q20_fir_residual_filter_unit_test.sv @@
module adaptive_q20_fir_residual_filter_unit_test;
  import aqfir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Settling wait that covers the slowest word (order 32, adapting) with margin.
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned WatchLimit   = 20000;

  // Word offered on the input channel.
  typedef struct packed {
    logic [DataW-1:0] sample;
    logic             block_start;
  } in_word_t;

  // Word expected on the result channel.
  typedef struct packed {
    logic [DataW-1:0]  result_sample;
    logic [DataW-1:0]  prediction_value;
    logic              prediction_clamped;
    logic              modular_wrapped;
    logic [ClampW-1:0] coefficient_clamps;
    logic              adapted;
  } res_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [ProfW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [DataW-1:0] in_sample;
  logic in_block_start;
  logic out_valid;
  logic out_ready;
  logic signed [DataW-1:0] out_result_sample;
  logic signed [DataW-1:0] out_prediction_value;
  logic out_prediction_clamped;
  logic out_modular_wrapped;
  logic [ClampW-1:0] out_coefficient_clamps;
  logic out_adapted;

  adaptive_q20_fir_residual_filter_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_sample              (in_sample),
    .in_block_start         (in_block_start),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_sample      (out_result_sample),
    .out_prediction_value   (out_prediction_value),
    .out_prediction_clamped (out_prediction_clamped),
    .out_modular_wrapped    (out_modular_wrapped),
    .out_coefficient_clamps (out_coefficient_clamps),
    .out_adapted            (out_adapted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of weights, history ring, energy and config.
  // ---------------------------------------------------------------------------
  logic [ProfW-1:0]       p_profile;
  logic                   p_inverse;
  logic signed [63:0]     p_weight [32];
  logic signed [31:0]     p_hist   [32];
  int unsigned            p_head;
  logic [67:0]            p_energy;   // 68-bit wrapping energy
  logic [1:0]             p_phase;

  in_word_t  pending_words [$];
  res_word_t expected_words[$];

  int unsigned errors;
  int unsigned words_in, words_out, adapt_seen, clamp_seen, wrap_seen, pclamp_seen;
  bit          idle_enable;    // random gaps on
  bit          hold_off_req;   // long receiver stall request

  function automatic void filter_clear();
    for (int i = 0; i < 32; i++) begin
      p_weight[i] = 0;
      p_hist[i]   = 0;
    end
    p_head   = 0;
    p_energy = 68'd1;
    p_phase  = 2'd0;
  endfunction

  // ceil(log2(energy)) = bit length of (energy - 1), modulo 2^68
  function automatic int unsigned energy_log2();
    logic [67:0] e;
    int unsigned n;
    e = p_energy - 68'd1;
    n = 0;
    for (int i = 0; i < 68; i++)
      if (e[i]) n = i + 1;
    return n;
  endfunction

  function automatic res_word_t filter_predict(in_word_t w);
    res_word_t r;
    int unsigned order, shift, nh, lg;
    logic signed [127:0] acc;
    logic signed [63:0] pred, orig, diff, x, h, upd, wn;
    logic [63:0] ud, mag, q, cap, hm;
    logic [31:0] res;
    int s;
    bit neg;
    logic [127:0] wide;

    if (w.block_start) filter_clear();
    order = 0;
    shift = 0;
    case (p_profile)
      PROF_O8S3:  begin order = 8;  shift = 3; end
      PROF_O8S5:  begin order = 8;  shift = 5; end
      PROF_O32S3: begin order = 32; shift = 3; end
      PROF_O32S5: begin order = 32; shift = 5; end
      default:    begin order = 0;  shift = 0; end
    endcase
    x = 64'(signed'(w.sample));
    r = '0;

    acc = 0;
    for (int j = 0; j < order; j++)
      acc += 128'(p_weight[j]) * 128'(p_hist[(p_head + j) % order]);
    // floor division by 2^20 (arithmetic shift floors)
    acc = acc >>> QBits;
    if (acc < -128'sd2147483648) begin
      pred = -64'sd2147483648;
      r.prediction_clamped = 1'b1;
    end else if (acc > 128'sd2147483647) begin
      pred = 64'sd2147483647;
      r.prediction_clamped = 1'b1;
    end else begin
      pred = 64'(acc);
    end

    if (p_inverse) begin
      res  = w.sample + pred[31:0];
      orig = 64'(signed'(res));
    end else begin
      orig = x;
      res  = w.sample - pred[31:0];
    end
    diff = orig - pred;
    r.modular_wrapped = (diff < -64'sd2147483648) || (diff > 64'sd2147483647);

    // every fourth word of a block: normalised weight update
    if (order != 0 && p_phase == 2'd3) begin
      lg  = energy_log2();
      s   = int'(lg) + int'(shift) - int'(QBits);
      ud  = diff < 0 ? -diff : diff;
      cap = 64'd1 << 22;
      r.adapted = 1'b1;
      for (int j = 0; j < order; j++) begin
        h   = 64'(p_hist[(p_head + j) % order]);
        hm  = h < 0 ? -h : h;
        mag = ud * hm;
        neg = (diff < 0) != (h < 0);
        if (s >= 64) q = 0;
        else if (s >= 0) q = mag >> s;
        else begin
          wide = 128'(mag) << (-s);
          q = (wide > 128'(cap)) ? cap : wide[63:0];
        end
        if (q > cap) q = cap;
        upd = neg ? -signed'(q) : signed'(q);
        wn  = p_weight[j] + upd;
        if (wn < -64'sd1048576) begin
          wn = -64'sd1048576;
          r.coefficient_clamps++;
        end else if (wn > 64'sd1048576) begin
          wn = 64'sd1048576;
          r.coefficient_clamps++;
        end
        p_weight[j] = wn;
      end
    end

    // push the original into the ring; energy tracks sum of squares + 1
    if (order != 0) begin
      nh = (p_head + order - 1) % order;
      h  = 64'(p_hist[nh]);
      hm = h < 0 ? -h : h;
      p_energy = p_energy - 68'(hm * hm);
      hm = orig[31:0] == 32'h8000_0000 ? 64'd2147483648 :
           (orig < 0 ? -orig : orig);
      p_energy = p_energy + 68'(hm * hm);
      p_head = nh;
      p_hist[nh] = orig[31:0];
    end
    p_phase++;

    r.result_sample    = res;
    r.prediction_value = pred[31:0];
    return r;
  endfunction

  function automatic void filter_feed(in_word_t w);
    expected_words.push_back(filter_predict(w));
    words_in++;
  endfunction

  task automatic result_check();
    res_word_t e;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word: result %h", $time, out_result_sample);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    words_out++;
    if (out_adapted) adapt_seen++;
    if (out_coefficient_clamps != 0) clamp_seen++;
    if (out_modular_wrapped) wrap_seen++;
    if (out_prediction_clamped) pclamp_seen++;
    if (out_result_sample !== e.result_sample) begin
      $display("%0t: result_sample expected %h actual %h", $time,
               e.result_sample, out_result_sample);
      errors++;
    end
    if (out_prediction_value !== e.prediction_value) begin
      $display("%0t: prediction_value expected %h actual %h", $time,
               e.prediction_value, out_prediction_value);
      errors++;
    end
    if (out_prediction_clamped !== e.prediction_clamped) begin
      $display("%0t: prediction_clamped expected %b actual %b", $time,
               e.prediction_clamped, out_prediction_clamped);
      errors++;
    end
    if (out_modular_wrapped !== e.modular_wrapped) begin
      $display("%0t: modular_wrapped expected %b actual %b", $time,
               e.modular_wrapped, out_modular_wrapped);
      errors++;
    end
    if (out_coefficient_clamps !== e.coefficient_clamps) begin
      $display("%0t: coefficient_clamps expected %0d actual %0d", $time,
               e.coefficient_clamps, out_coefficient_clamps);
      errors++;
    end
    if (out_adapted !== e.adapted) begin
      $display("%0t: adapted expected %b actual %b", $time, e.adapted, out_adapted);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sender with random gap bursts, fed from pending_words.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;
  bit          send_hold;   // sender pause requested by stimulus

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        filter_feed(in_word_t'{in_sample, in_block_start});
      end
      if (!in_valid || in_ready) begin
        // slot free for the next word (either empty or just accepted)
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 && !send_hold) begin
          in_word_t w;
          w = pending_words.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= w.sample;
          in_block_start <= w.block_start;
          if (idle_enable && $urandom_range(0, 3) == 0)
            send_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stalls, compares each result word with the oldest one due.
  // ---------------------------------------------------------------------------
  int unsigned recv_gap;
  int unsigned hold_count;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_gap   <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) result_check();
      if (hold_off_req && hold_count == 0) begin
        hold_count <= 400;   // long stall so the block backs up
        out_ready  <= 1'b0;
      end else if (hold_count > 1) begin
        hold_count <= hold_count - 1;
        out_ready  <= 1'b0;
      end else if (hold_count == 1) begin
        hold_count <= hold_off_req ? 1 : 0;
        out_ready  <= !hold_off_req;
      end else if (recv_gap != 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        recv_gap  <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no word moved on either channel.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (pending_words.size() == 0 && expected_words.size() == 0 && !in_valid)
        || hold_count != 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired, %0d words still due", $time,
               expected_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sample with a mix of extremes, small values and full-range noise.
  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 64) - 32;
      3, 4:    return $urandom;
      default: return 32'(signed'($urandom_range(0, 2000000) - 1000000));
    endcase
  endfunction

  task automatic queue_word(logic [31:0] s, logic bs);
    pending_words.push_back(in_word_t'{s, bs});
  endtask

  // Wait until all words accepted and every result arrived, then settle.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [ProfW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_PROFILE) p_profile = val;
    else p_inverse = val[0];
  endtask

  // Stream of subframes: mostly well-formed blocks, some mid-block starts.
  task automatic queue_blocks(int unsigned n);
    int unsigned left;
    left = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (left == 0) left = $urandom_range(4, 60);
      queue_word(random_sample(),
                 (left == 1) ? 1'b0 : ($urandom_range(0, 40) == 0));
      left--;
      if (left == 0 && i + 1 < n) queue_word(random_sample(), 1'b1);
    end
  endtask

  initial begin
    logic [ProfW-1:0] prof;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_PROFILE; cfg_data = '0;
    in_valid = 1'b0; in_sample = '0; in_block_start = 1'b0;
    out_ready = 1'b0;
    errors = 0; words_in = 0; words_out = 0;
    adapt_seen = 0; clamp_seen = 0; wrap_seen = 0; pclamp_seen = 0;
    idle_enable = 1'b1; hold_off_req = 1'b0; send_hold = 1'b0;
    p_profile = PROF_OFF;
    p_inverse = 1'b0;
    filter_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: profile off passes samples through; no block_start on the first words after reset.
    queue_word(32'h7fff_ffff, 1'b0);
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'hffff_ffff, 1'b1);
    drain();

    // Directed: order 8, large same-sign samples drive weight and step clamps.
    reg_write(CFG_PROFILE, PROF_O8S3);
    queue_word(32'h7fff_ffff, 1'b1);
    for (int i = 0; i < 11; i++) queue_word(32'h7fff_ffff, 1'b0);
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h0000_0001, 1'b0);
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h7fff_ffff, 1'b0);
    drain();

    // Directed: inverse mode at order 32, profile change mid-block, odd profile.
    reg_write(CFG_INVERSE, ProfW'(1));
    reg_write(CFG_PROFILE, PROF_O32S5);
    queue_word(32'h0000_1000, 1'b1);
    for (int i = 0; i < 5; i++) queue_word(32'h8000_0000 + i, 1'b0);
    drain();
    reg_write(CFG_PROFILE, 3'd7);
    queue_word(32'h1234_5678, 1'b0);
    queue_word(32'hedcb_a987, 1'b0);
    drain();

    // Random phases over every profile (off, defined, undefined) and both modes.
    for (int ph = 0; ph < 10; ph++) begin
      prof = (ph < 8) ? ProfW'(ph % 5) : ProfW'($urandom_range(5, 7));
      reg_write(CFG_PROFILE, prof);
      reg_write(CFG_INVERSE, ProfW'(ph[0]));
      if (ph == 4) begin
        // receiver stalls long while the sender keeps offering
        hold_off_req = 1'b1;
        queue_blocks(40);
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (ph == 6) begin
        // sender stops with words still queued until every result is back
        queue_blocks(60);
        while (pending_words.size() > 30) @(posedge clk);
        send_hold = 1'b1;
        @(posedge clk);
        while (expected_words.size() != 0 || in_valid) @(posedge clk);
        send_hold = 1'b0;
      end else begin
        queue_blocks(70);
      end
      if (ph == 8) idle_enable = 1'b0;   // no gaps in the final stretch
      drain();
    end

    $display("Covered %0d words in, %0d out: %0d adapting, %0d with weight clamps,",
             words_in, words_out, adapt_seen, clamp_seen);
    $display("%0d wrapped differences, %0d saturated predictions, all profiles and modes.",
             wrap_seen, pclamp_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
